// File: src/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// shared types and constants of the grid ray caster
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int MAP_DIM_DEF        = 64;
  localparam int SCREEN_COLUMNS_DEF = 640;

  localparam int POS_W      = 22;
  localparam int DIR_W      = 16;
  localparam int GRID_W     = 7;
  localparam int CELL_W     = 6;
  localparam int SCOL_W     = 10;
  localparam int DIST_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int DIVQ_W     = 32;
  localparam int DIVD_W     = 17;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X    = 3'd0,
    CFG_POS_Y    = 3'd1,
    CFG_DIR_X    = 3'd2,
    CFG_DIR_Y    = 3'd3,
    CFG_PLANE_X  = 3'd4,
    CFG_PLANE_Y  = 3'd5,
    CFG_GRID_W   = 3'd6,
    CFG_GRID_H   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic              is_cast;
    logic [SCOL_W-1:0] screen_column;
    logic [CELL_W-1:0] cell_column;
    logic [CELL_W-1:0] cell_row;
    logic              cell_is_wall;
  } gcr_item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } gcr_ctl_t;

endpackage

// File: src/gcr_front.sv
// ----------------------------------------------------------------------------
// gcr_front
// accepts items, tags them as cell writes or casts, two-entry queue
// ----------------------------------------------------------------------------
module gcr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [gcr_pkg::SCOL_W-1:0] in_screen_column,
  input  logic [gcr_pkg::CELL_W-1:0] in_cell_column,
  input  logic [gcr_pkg::CELL_W-1:0] in_cell_row,
  input  logic                       in_cell_is_wall,
  input  gcr_pkg::gcr_ctl_t          ctl,
  output logic                       q_valid,
  output gcr_pkg::gcr_item_t         q_item
);
  import gcr_pkg::*;

  gcr_item_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign in_stall = ctl.clearing || (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = ctl.pop && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{is_cast: in_action, screen_column: in_screen_column,
                            cell_column: in_cell_column, cell_row: in_cell_row,
                            cell_is_wall: in_cell_is_wall};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: src/gcr_div.sv
// ----------------------------------------------------------------------------
// gcr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gcr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gcr_pkg::DIVQ_W-1:0] dividend,
  input  logic [gcr_pkg::DIVD_W-1:0] divisor,
  output logic                       done,
  output logic [gcr_pkg::DIVQ_W-1:0] quotient
);
  import gcr_pkg::*;

  localparam int CNT_W = $clog2(DIVQ_W + 1);

  logic [DIVD_W:0]   rem_r;
  logic [DIVQ_W-1:0] quo_r;
  logic [DIVD_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVD_W:0]   rem_sh;
  logic [DIVD_W:0]   diff;
  logic              fits;

  assign rem_sh   = {rem_r[DIVD_W-1:0], quo_r[DIVQ_W-1]};
  assign diff     = rem_sh - {1'b0, dvs_r};
  assign fits     = (rem_sh >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff : rem_sh;
      quo_r <= {quo_r[DIVQ_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVQ_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// File: src/gcr_back.sv
// ----------------------------------------------------------------------------
// gcr_back
// wall map, ray setup and grid stepping, result register
// ----------------------------------------------------------------------------
module gcr_back #(
  parameter int MAP_DIM        = gcr_pkg::MAP_DIM_DEF,
  parameter int SCREEN_COLUMNS = gcr_pkg::SCREEN_COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  gcr_pkg::gcr_item_t         q_item,
  output gcr_pkg::gcr_ctl_t          ctl,
  input  logic [gcr_pkg::POS_W-1:0]  position_x,
  input  logic [gcr_pkg::POS_W-1:0]  position_y,
  input  logic signed [gcr_pkg::DIR_W-1:0] view_dir_x,
  input  logic signed [gcr_pkg::DIR_W-1:0] view_dir_y,
  input  logic signed [gcr_pkg::DIR_W-1:0] camera_plane_x,
  input  logic signed [gcr_pkg::DIR_W-1:0] camera_plane_y,
  input  logic [gcr_pkg::GRID_W-1:0] grid_width,
  input  logic [gcr_pkg::GRID_W-1:0] grid_height,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gcr_pkg::CELL_W-1:0] out_hit_column,
  output logic [gcr_pkg::CELL_W-1:0] out_hit_row,
  output logic                       out_hit_side,
  output logic                       out_left_grid,
  output logic                       out_step_x_negative,
  output logic                       out_step_y_negative,
  output logic [gcr_pkg::DIST_W-1:0] out_side_distance_x,
  output logic [gcr_pkg::DIST_W-1:0] out_side_distance_y,
  output logic [gcr_pkg::DIST_W-1:0] out_delta_distance_x,
  output logic [gcr_pkg::DIST_W-1:0] out_delta_distance_y
);
  import gcr_pkg::*;

  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int LD    = $clog2(MAP_DIM);
  localparam int CW    = ((LD > CELL_W) ? LD : CELL_W) + 2;
  localparam int WW    = ($clog2(MAP_DIM + 1) > GRID_W) ? $clog2(MAP_DIM + 1) : GRID_W;
  localparam int BW    = CW + WW;
  localparam int CAM_W = 28;
  localparam int PRD_W = CAM_W + DIR_W;
  localparam int RSUM_W = PRD_W - 16 + 1;
  localparam int SPAN_W = 17;

  // camera coordinate floor(col * 2^17 / SCREEN_COLUMNS) - 2^16 by reciprocal multiply
  localparam int REC_N     = SCOL_W + 17;
  localparam int REC_K     = REC_N + $clog2(SCREEN_COLUMNS);
  localparam int REC_SH    = REC_K - 17;
  localparam int CAM_PRD_W = SCOL_W + REC_N + 1;
  localparam longint unsigned REC_M =
    ((64'd1 << REC_K) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MULX, ST_MULY, ST_DIVX, ST_DIVY,
    ST_SXA, ST_SXB, ST_SYA, ST_SYB, ST_STEP, ST_CHECK, ST_EMIT
  } state_t;

  state_t state_r;

  logic                     wall_mem [DEPTH];
  logic                     rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic                     wr_data;
  logic [AW-1:0]            clr_cnt_r;

  logic                     div_start_r;
  logic [DIVQ_W-1:0]        div_a_r;
  logic [DIVD_W-1:0]        div_b_r;
  logic                     div_done;
  logic [DIVQ_W-1:0]        div_q;

  logic [CAM_PRD_W-1:0]     cam_prod;
  logic signed [CAM_W-1:0]  cam_r;
  logic signed [DIR_W-1:0]  rx_r;
  logic signed [DIR_W-1:0]  ry_r;
  logic [DIST_W-1:0]        dx_r;
  logic [DIST_W-1:0]        dy_r;
  logic [DIST_W-1:0]        sx_r;
  logic [DIST_W-1:0]        sy_r;
  logic [SPAN_W+15:0]       lo_r;
  logic signed [CW-1:0]     mx_r;
  logic signed [CW-1:0]     my_r;
  logic                     side_r;
  logic                     left_r;

  logic [CELL_W-1:0]        hit_col_r;
  logic [CELL_W-1:0]        hit_row_r;
  logic                     hit_side_r;
  logic                     left_out_r;
  logic                     stx_neg_r;
  logic                     sty_neg_r;
  logic [DIST_W-1:0]        osx_r;
  logic [DIST_W-1:0]        osy_r;
  logic [DIST_W-1:0]        odx_r;
  logic [DIST_W-1:0]        ody_r;
  logic                     out_valid_r;

  // ray component: dir + floor(plane * cam / 2^16), saturated
  logic signed [DIR_W-1:0]  mul_plane;
  logic signed [DIR_W-1:0]  mul_dir;
  logic signed [PRD_W-1:0]  ray_prod;
  logic signed [RSUM_W-1:0] ray_sum;
  logic signed [DIR_W-1:0]  ray_sat;

  // side distance partial products
  logic [SPAN_W-1:0]        span;
  logic [15:0]              mul_half;
  logic [SPAN_W+15:0]       span_prod;
  logic [DIST_W-1:0]        dcur;
  logic [SPAN_W+16:0]       side_sum;

  // stepping
  logic                     take_x;
  logic signed [CW-1:0]     nx;
  logic signed [CW-1:0]     ny;
  logic [DIST_W:0]          add_s;
  logic [DIST_W-1:0]        add_a;
  logic [DIST_W-1:0]        add_b;
  logic [DIST_W-1:0]        add_res;
  logic [WW-1:0]            w_eff;
  logic [WW-1:0]            h_eff;
  logic                     outside;
  logic                     wr_in_range;
  logic                     out_free;

  gcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cam_prod  = CAM_PRD_W'(q_item.screen_column) * CAM_PRD_W'(REC_M);

  assign mul_plane = (state_r == ST_MULX) ? camera_plane_x : camera_plane_y;
  assign mul_dir   = (state_r == ST_MULX) ? view_dir_x : view_dir_y;
  assign ray_prod  = PRD_W'(mul_plane) * PRD_W'(cam_r);
  assign ray_sum   = RSUM_W'(mul_dir) + RSUM_W'(ray_prod >>> 16);

  always_comb begin
    if (ray_sum > RSUM_W'(32767))        ray_sat = 16'sh7fff;
    else if (ray_sum < -RSUM_W'(32768))  ray_sat = 16'sh8000;
    else                                  ray_sat = ray_sum[DIR_W-1:0];
  end

  function automatic logic [DIVD_W-1:0] mag(input logic signed [DIR_W-1:0] v);
    logic [DIVD_W-1:0] e;
    e = DIVD_W'(v);
    return v[DIR_W-1] ? (~e + DIVD_W'(1)) : e;
  endfunction

  // span and multiplier operand per side state
  always_comb begin
    logic [15:0] frac;
    logic        neg;
    if (state_r == ST_SXA || state_r == ST_SXB) begin
      frac = position_x[15:0];
      neg  = rx_r[DIR_W-1];
      dcur = dx_r;
    end else begin
      frac = position_y[15:0];
      neg  = ry_r[DIR_W-1];
      dcur = dy_r;
    end
    span     = neg ? SPAN_W'(frac) : (SPAN_W'(65536) - SPAN_W'(frac));
    mul_half = (state_r == ST_SXA || state_r == ST_SYA) ? dcur[15:0] : dcur[31:16];
  end

  assign span_prod = span * (SPAN_W + 16)'(mul_half);
  assign side_sum  = (SPAN_W + 17)'(span_prod) + (SPAN_W + 17)'(lo_r >> 16);

  assign w_eff = (WW'(grid_width) > WW'(MAP_DIM)) ? WW'(MAP_DIM) : WW'(grid_width);
  assign h_eff = (WW'(grid_height) > WW'(MAP_DIM)) ? WW'(MAP_DIM) : WW'(grid_height);

  assign take_x = (sx_r <= sy_r);
  always_comb begin
    nx    = mx_r;
    ny    = my_r;
    add_a = take_x ? sx_r : sy_r;
    add_b = take_x ? dx_r : dy_r;
    if (take_x) nx = rx_r[DIR_W-1] ? (mx_r - CW'(1)) : (mx_r + CW'(1));
    else        ny = ry_r[DIR_W-1] ? (my_r - CW'(1)) : (my_r + CW'(1));
  end
  assign add_s   = {1'b0, add_a} + {1'b0, add_b};
  assign add_res = (add_a == DIST_INF || add_b == DIST_INF || add_s[DIST_W]) ?
                   DIST_INF : add_s[DIST_W-1:0];

  assign outside = nx[CW-1] || ny[CW-1] ||
                   (BW'(unsigned'(nx)) >= BW'(w_eff)) ||
                   (BW'(unsigned'(ny)) >= BW'(h_eff));

  assign rd_addr = AW'(AW'(unsigned'(ny)) * AW'(MAP_DIM) + AW'(unsigned'(nx)));

  assign wr_in_range = (32'(q_item.cell_column) < MAP_DIM) &&
                       (32'(q_item.cell_row) < MAP_DIM);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = 1'b0;
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (state_r == ST_IDLE && q_valid && !q_item.is_cast && wr_in_range) begin
      wr_en   = 1'b1;
      wr_addr = AW'(AW'(q_item.cell_row) * AW'(MAP_DIM) + AW'(q_item.cell_column));
      wr_data = q_item.cell_is_wall;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) wall_mem[wr_addr] <= wr_data;
    rd_data_r <= wall_mem[rd_addr];
  end

  assign ctl.pop      = (state_r == ST_IDLE) && q_valid;
  assign ctl.clearing = (state_r == ST_CLEAR);
  assign out_free     = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == ST_MULY) || (state_r == ST_DIVX && div_done);
      if (state_r == ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(DEPTH - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid && q_item.is_cast) begin
            cam_r   <= CAM_W'(cam_prod >> REC_SH) - CAM_W'(65536);
            mx_r    <= CW'(position_x[POS_W-1:16]);
            my_r    <= CW'(position_y[POS_W-1:16]);
            state_r <= ST_MULX;
          end
        end
        ST_MULX: begin
          rx_r    <= ray_sat;
          state_r <= ST_MULY;
        end
        ST_MULY: begin
          ry_r    <= ray_sat;
          div_a_r <= DIVQ_W'(1) << 30;
          div_b_r <= mag(rx_r);
          state_r <= ST_DIVX;
        end
        ST_DIVX: begin
          if (div_done) begin
            dx_r    <= (rx_r == '0) ? DIST_INF : div_q;
            div_a_r <= DIVQ_W'(1) << 30;
            div_b_r <= mag(ry_r);
            state_r <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            dy_r    <= (ry_r == '0) ? DIST_INF : div_q;
            state_r <= ST_SXA;
          end
        end
        ST_SXA: begin
          lo_r    <= span_prod;
          state_r <= ST_SXB;
        end
        ST_SXB: begin
          sx_r    <= (dx_r == DIST_INF) ? DIST_INF : side_sum[DIST_W-1:0];
          state_r <= ST_SYA;
        end
        ST_SYA: begin
          lo_r    <= span_prod;
          state_r <= ST_SYB;
        end
        ST_SYB: begin
          sy_r    <= (dy_r == DIST_INF) ? DIST_INF : side_sum[DIST_W-1:0];
          state_r <= ST_STEP;
        end
        ST_STEP: begin
          mx_r   <= nx;
          my_r   <= ny;
          side_r <= !take_x;
          if (take_x) sx_r <= add_res;
          else        sy_r <= add_res;
          left_r <= outside;
          state_r <= outside ? ST_EMIT : ST_CHECK;
        end
        ST_CHECK: begin
          state_r <= rd_data_r ? ST_EMIT : ST_STEP;
        end
        ST_EMIT: begin
          if (out_free) begin
            hit_col_r   <= mx_r[CELL_W-1:0];
            hit_row_r   <= my_r[CELL_W-1:0];
            hit_side_r  <= side_r;
            left_out_r  <= left_r;
            stx_neg_r   <= rx_r[DIR_W-1];
            sty_neg_r   <= ry_r[DIR_W-1];
            osx_r       <= sx_r;
            osy_r       <= sy_r;
            odx_r       <= dx_r;
            ody_r       <= dy_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit_column       = hit_col_r;
  assign out_hit_row          = hit_row_r;
  assign out_hit_side         = hit_side_r;
  assign out_left_grid        = left_out_r;
  assign out_step_x_negative  = stx_neg_r;
  assign out_step_y_negative  = sty_neg_r;
  assign out_side_distance_x  = osx_r;
  assign out_side_distance_y  = osy_r;
  assign out_delta_distance_x = odx_r;
  assign out_delta_distance_y = ody_r;

endmodule

// File: src/grid_ray_caster_unit.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_unit
// column ray caster over a one-bit wall map, grid traversal in fixed point
// ----------------------------------------------------------------------------
// in_ channel: action 0 writes one map cell, action 1 casts the ray of a
// screen column; a transfer happens when in_valid is high and in_stall low.
// out_ channel: one result per cast, none for writes, held while out_stall.
// cfg_ port: write-only, cfg_index selects the register; the user must
// write it only while idle, the block does not enforce this. after reset
// the wall map is cleared one cell a cycle, all MAP_DIM*MAP_DIM cells
// (4096 by default), with in_stall high the whole time. a cast first
// computes the ray components, then makes two passes of the one radix-2
// divider (both step distances), then the side distances; then each grid
// step is a step and a map read, the step that leaves the grid skips the
// read, and the result goes to the output register. a two-entry queue
// keeps taking items while a cast runs, until full; the output register
// holds a result under out_stall and the sequencer waits for it.
// ----------------------------------------------------------------------------
module grid_ray_caster_unit #(
  parameter int MAP_DIM        = gcr_pkg::MAP_DIM_DEF,
  parameter int SCREEN_COLUMNS = gcr_pkg::SCREEN_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [gcr_pkg::SCOL_W-1:0]     in_screen_column,
  input  logic [gcr_pkg::CELL_W-1:0]     in_cell_column,
  input  logic [gcr_pkg::CELL_W-1:0]     in_cell_row,
  input  logic                           in_cell_is_wall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gcr_pkg::CELL_W-1:0]     out_hit_column,
  output logic [gcr_pkg::CELL_W-1:0]     out_hit_row,
  output logic                           out_hit_side,
  output logic                           out_left_grid,
  output logic                           out_step_x_negative,
  output logic                           out_step_y_negative,
  output logic [gcr_pkg::DIST_W-1:0]     out_side_distance_x,
  output logic [gcr_pkg::DIST_W-1:0]     out_side_distance_y,
  output logic [gcr_pkg::DIST_W-1:0]     out_delta_distance_x,
  output logic [gcr_pkg::DIST_W-1:0]     out_delta_distance_y,
  input  logic                           cfg_wr_en,
  input  logic [gcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gcr_pkg::*;

  logic [POS_W-1:0]        pos_x_r;
  logic [POS_W-1:0]        pos_y_r;
  logic signed [DIR_W-1:0] dir_x_r;
  logic signed [DIR_W-1:0] dir_y_r;
  logic signed [DIR_W-1:0] plane_x_r;
  logic signed [DIR_W-1:0] plane_y_r;
  logic [GRID_W-1:0]       grid_w_r;
  logic [GRID_W-1:0]       grid_h_r;

  gcr_ctl_t  ctl;
  logic      q_valid;
  gcr_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      dir_x_r   <= 16'sd16384;
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= '0;
      grid_w_r  <= GRID_W'(64);
      grid_h_r  <= GRID_W'(64);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POS_X:   pos_x_r   <= cfg_data[POS_W-1:0];
        CFG_POS_Y:   pos_y_r   <= cfg_data[POS_W-1:0];
        CFG_DIR_X:   dir_x_r   <= cfg_data[DIR_W-1:0];
        CFG_DIR_Y:   dir_y_r   <= cfg_data[DIR_W-1:0];
        CFG_PLANE_X: plane_x_r <= cfg_data[DIR_W-1:0];
        CFG_PLANE_Y: plane_y_r <= cfg_data[DIR_W-1:0];
        CFG_GRID_W:  grid_w_r  <= cfg_data[GRID_W-1:0];
        CFG_GRID_H:  grid_h_r  <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  gcr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_screen_column (in_screen_column),
    .in_cell_column   (in_cell_column),
    .in_cell_row      (in_cell_row),
    .in_cell_is_wall  (in_cell_is_wall),
    .ctl              (ctl),
    .q_valid          (q_valid),
    .q_item           (q_item)
  );

  gcr_back #(
    .MAP_DIM        (MAP_DIM),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .ctl                  (ctl),
    .position_x           (pos_x_r),
    .position_y           (pos_y_r),
    .view_dir_x           (dir_x_r),
    .view_dir_y           (dir_y_r),
    .camera_plane_x       (plane_x_r),
    .camera_plane_y       (plane_y_r),
    .grid_width           (grid_w_r),
    .grid_height          (grid_h_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_hit_column       (out_hit_column),
    .out_hit_row          (out_hit_row),
    .out_hit_side         (out_hit_side),
    .out_left_grid        (out_left_grid),
    .out_step_x_negative  (out_step_x_negative),
    .out_step_y_negative  (out_step_y_negative),
    .out_side_distance_x  (out_side_distance_x),
    .out_side_distance_y  (out_side_distance_y),
    .out_delta_distance_x (out_delta_distance_x),
    .out_delta_distance_y (out_delta_distance_y)
  );

endmodule

// File: tb/sv/tb_grid_ray_caster_unit.sv
// ----------------------------------------------------------------------------
// tb_grid_ray_caster_unit
// self-checking testbench of the grid ray caster
// ----------------------------------------------------------------------------
// map writes and column casts go in over the in_ channel while a scoreboard
// predicts every cast from its own copy of the camera registers and the wall
// map. directed rays come first, then random scenes under random gaps and
// stalls, then one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_grid_ray_caster_unit;
  import gcr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    logic [CELL_W-1:0] hit_column;
    logic [CELL_W-1:0] hit_row;
    logic              hit_side;
    logic              left_grid;
    logic              step_x_neg;
    logic              step_y_neg;
    logic [DIST_W-1:0] side_x;
    logic [DIST_W-1:0] side_y;
    logic [DIST_W-1:0] delta_x;
    logic [DIST_W-1:0] delta_y;
  } ray_hit_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = 1'b0;
  logic [SCOL_W-1:0]     in_screen_column = '0;
  logic [CELL_W-1:0]     in_cell_column = '0;
  logic [CELL_W-1:0]     in_cell_row = '0;
  logic                  in_cell_is_wall = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CELL_W-1:0]     out_hit_column;
  logic [CELL_W-1:0]     out_hit_row;
  logic                  out_hit_side;
  logic                  out_left_grid;
  logic                  out_step_x_negative;
  logic                  out_step_y_negative;
  logic [DIST_W-1:0]     out_side_distance_x;
  logic [DIST_W-1:0]     out_side_distance_y;
  logic [DIST_W-1:0]     out_delta_distance_x;
  logic [DIST_W-1:0]     out_delta_distance_y;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // camera state and wall map as the block should hold them
  logic [POS_W-1:0]  cam_pos_x, cam_pos_y;
  int                cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
  int                grid_cols, grid_rows;
  bit                wall_cells [MAP_DIM_DEF*MAP_DIM_DEF];

  ray_hit_t pending_hits [$];
  int       fail_count = 0;
  int       cast_count = 0;
  int       write_count = 0;
  int       escaped_count = 0;
  int       hit_count = 0;
  longint   cycle_count = 0;
  bit       send_gaps = 1'b1;
  bit       sink_stalls = 1'b1;
  int       hold_request = 0;

  grid_ray_caster_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_ray_caster_unit verification failed");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls, plus a long hold-off on request
  always @(posedge clk) begin : sink_ctl
    int hold_left;
    int hold_seen;
    int burst;
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst > 0) begin
      burst--;
      out_stall <= 1'b1;
    end else if (sink_stalls) begin
      burst = idle_len();
      out_stall <= (burst > 0);
      if (burst > 0) burst--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int steer(int d, int p, longint cam);
    longint r;
    r = longint'(d) + ((longint'(p) * cam) >>> 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  function automatic logic [DIST_W-1:0] step_length(int d);
    longint unsigned m;
    if (d == 0) return DIST_INF;
    m = (d < 0) ? -d : d;
    return DIST_W'(64'h4000_0000 / m);
  endfunction

  function automatic logic [DIST_W-1:0] first_side(logic [POS_W-1:0] pos, int d,
                                                   logic [DIST_W-1:0] delta);
    longint unsigned span;
    if (delta == DIST_INF) return DIST_INF;
    span = (d < 0) ? pos[15:0] : (65536 - pos[15:0]);
    return DIST_W'((span * delta) >> 16);
  endfunction

  function automatic logic [DIST_W-1:0] add_sat(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = a + b;
    if (a == DIST_INF || b == DIST_INF || s[DIST_W]) return DIST_INF;
    return s[DIST_W-1:0];
  endfunction

  // walks the grid from the viewer along the ray of one screen column
  function automatic ray_hit_t trace_column(logic [SCOL_W-1:0] col);
    ray_hit_t h;
    longint cam;
    int rx, ry, mx, my, sx, sy, w, ht;
    logic [DIST_W-1:0] side_x, side_y, dx, dy;
    logic side;
    logic escaped;
    cam = ((longint'(col) * 2 * 65536) / SCREEN_COLUMNS_DEF) - 65536;
    rx = steer(cam_dir_x, cam_plane_x, cam);
    ry = steer(cam_dir_y, cam_plane_y, cam);
    dx = step_length(rx);
    dy = step_length(ry);
    mx = cam_pos_x >> 16;
    my = cam_pos_y >> 16;
    sx = rx < 0 ? -1 : 1;
    sy = ry < 0 ? -1 : 1;
    side_x = first_side(cam_pos_x, rx, dx);
    side_y = first_side(cam_pos_y, ry, dy);
    w = grid_cols < MAP_DIM_DEF ? grid_cols : MAP_DIM_DEF;
    ht = grid_rows < MAP_DIM_DEF ? grid_rows : MAP_DIM_DEF;
    escaped = 1'b0;
    forever begin
      if (side_x <= side_y) begin
        side_x = add_sat(side_x, dx);
        mx += sx;
        side = 1'b0;
      end else begin
        side_y = add_sat(side_y, dy);
        my += sy;
        side = 1'b1;
      end
      if (mx < 0 || my < 0 || mx >= w || my >= ht) begin
        escaped = 1'b1;
        break;
      end
      if (wall_cells[my*MAP_DIM_DEF + mx]) break;
    end
    h.hit_column = mx[CELL_W-1:0];
    h.hit_row = my[CELL_W-1:0];
    h.hit_side = side;
    h.left_grid = escaped;
    h.step_x_neg = sx < 0;
    h.step_y_neg = sy < 0;
    h.side_x = side_x;
    h.side_y = side_y;
    h.delta_x = dx;
    h.delta_y = dy;
    return h;
  endfunction

  always @(posedge clk) begin : hit_check
    ray_hit_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result, hit_column %0d hit_row %0d", out_hit_column, out_hit_row);
        fail_count++;
      end else begin
        e = pending_hits.pop_front();
        if (e.left_grid) escaped_count++;
        else hit_count++;
        if (e.hit_column !== out_hit_column) begin
          $error("hit_column exp %0d got %0d", e.hit_column, out_hit_column); fail_count++;
        end
        if (e.hit_row !== out_hit_row) begin
          $error("hit_row exp %0d got %0d", e.hit_row, out_hit_row); fail_count++;
        end
        if (e.hit_side !== out_hit_side) begin
          $error("hit_side exp %0d got %0d", e.hit_side, out_hit_side); fail_count++;
        end
        if (e.left_grid !== out_left_grid) begin
          $error("left_grid exp %0d got %0d", e.left_grid, out_left_grid); fail_count++;
        end
        if (e.step_x_neg !== out_step_x_negative) begin
          $error("step_x_negative exp %0d got %0d", e.step_x_neg, out_step_x_negative);
          fail_count++;
        end
        if (e.step_y_neg !== out_step_y_negative) begin
          $error("step_y_negative exp %0d got %0d", e.step_y_neg, out_step_y_negative);
          fail_count++;
        end
        if (e.side_x !== out_side_distance_x) begin
          $error("side_distance_x exp %h got %h", e.side_x, out_side_distance_x); fail_count++;
        end
        if (e.side_y !== out_side_distance_y) begin
          $error("side_distance_y exp %h got %h", e.side_y, out_side_distance_y); fail_count++;
        end
        if (e.delta_x !== out_delta_distance_x) begin
          $error("delta_distance_x exp %h got %h", e.delta_x, out_delta_distance_x);
          fail_count++;
        end
        if (e.delta_y !== out_delta_distance_y) begin
          $error("delta_distance_y exp %h got %h", e.delta_y, out_delta_distance_y);
          fail_count++;
        end
      end
    end
  end

  // one item over the in_ channel, predicted at its transfer
  task automatic send_item(logic action, logic [SCOL_W-1:0] scol, logic [CELL_W-1:0] ccol,
                           logic [CELL_W-1:0] crow, logic wall);
    int gap;
    gap = send_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_screen_column <= scol;
    in_cell_column <= ccol;
    in_cell_row <= crow;
    in_cell_is_wall <= wall;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (action) begin
      pending_hits.push_back(trace_column(scol));
      cast_count++;
    end else begin
      wall_cells[crow*MAP_DIM_DEF + ccol] = wall;
      write_count++;
    end
  endtask

  task automatic cast(logic [SCOL_W-1:0] scol);
    send_item(1'b1, scol, CELL_W'($urandom), CELL_W'($urandom), 1'($urandom));
  endtask

  task automatic put_cell(int c, int r, logic wall);
    send_item(1'b0, SCOL_W'($urandom), CELL_W'(c), CELL_W'(r), wall);
  endtask

  // drains the block so registers may change; writes leave no result behind
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      CFG_POS_X:   cam_pos_x = v[POS_W-1:0];
      CFG_POS_Y:   cam_pos_y = v[POS_W-1:0];
      CFG_DIR_X:   cam_dir_x = $signed(v[DIR_W-1:0]);
      CFG_DIR_Y:   cam_dir_y = $signed(v[DIR_W-1:0]);
      CFG_PLANE_X: cam_plane_x = $signed(v[DIR_W-1:0]);
      CFG_PLANE_Y: cam_plane_y = $signed(v[DIR_W-1:0]);
      CFG_GRID_W:  grid_cols = v[GRID_W-1:0];
      CFG_GRID_H:  grid_rows = v[GRID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(logic [21:0] px, logic [21:0] py, logic [15:0] dx, logic [15:0] dy,
                          logic [15:0] plx, logic [15:0] ply, logic [6:0] gw, logic [6:0] gh);
    wait_idle();
    cfg_write(CFG_POS_X, px);
    cfg_write(CFG_POS_Y, py);
    cfg_write(CFG_DIR_X, {6'b0, dx});
    cfg_write(CFG_DIR_Y, {6'b0, dy});
    cfg_write(CFG_PLANE_X, {6'b0, plx});
    cfg_write(CFG_PLANE_Y, {6'b0, ply});
    cfg_write(CFG_GRID_W, {15'b0, gw});
    cfg_write(CFG_GRID_H, {15'b0, gh});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_directed();
    // defaults: viewer at the corner looking along +x, clear map
    cast(10'd0);
    cast(10'd1023);
    put_cell(5, 0, 1'b1);
    put_cell(63, 63, 1'b1);
    put_cell(0, 0, 1'b1);
    cast(10'd320);
    // viewer inside a room, wide camera plane
    set_view(22'h03_8000, 22'h03_8000, 16'h4000, 16'h0000, 16'h0000, 16'h2A3D, 7'd64, 7'd64);
    put_cell(5, 0, 1'b0);
    put_cell(3, 6, 1'b1);
    cast(10'd0);
    cast(10'd319);
    cast(10'd639);
    cast(10'd1023);
    // both ray components zero, extreme negative directions
    set_view(22'h3F_FFFF, 22'h00_0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0, 7'd127);
    cast(10'd320);
    set_view(22'h3F_FFFF, 22'h3F_FFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 7'd127, 7'd1);
    cast(10'd0);
    cast(10'd1023);
    // start outside a narrow grid, casting back toward it
    set_view(22'h28_0000, 22'h02_4000, 16'hC000, 16'h1000, 16'h7FFF, 16'h7FFF, 7'd10, 7'd12);
    put_cell(8, 2, 1'b1);
    cast(10'd320);
    cast(10'd600);
    cast(10'd40);
  endtask

  task automatic random_view();
    logic [21:0] px, py;
    logic [6:0] gw, gh;
    case ($urandom_range(0, 5))
      0: gw = 7'd0;
      1: gw = 7'd127;
      2: gw = 7'd64;
      default: gw = 7'($urandom_range(1, 64));
    endcase
    gh = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
    if ($urandom_range(0, 5) == 0) begin
      px = 22'($urandom);
      py = 22'($urandom);
    end else begin
      px = {6'($urandom_range(0, (gw > 0 && gw < 64) ? gw - 1 : 63)), 16'($urandom)};
      py = {6'($urandom_range(0, (gh > 0 && gh < 64) ? gh - 1 : 63)), 16'($urandom)};
    end
    set_view(px, py, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), gw, gh);
  endtask

  task automatic test_random_scenes();
    int density;
    for (int phase = 0; phase < 14; phase++) begin
      random_view();
      send_gaps = (phase % 4) != 3;
      sink_stalls = (phase % 4) != 2;
      density = $urandom_range(5, 50);
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(0, 99) < 35)
          put_cell($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 99) < density);
        else
          cast(($urandom_range(0, 9) == 0) ? SCOL_W'($urandom) : SCOL_W'($urandom_range(0, 639)));
      end
    end
    send_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_backpressure();
    random_view();
    send_gaps = 1'b0;
    hold_request++;
    for (int i = 0; i < 10; i++) cast(SCOL_W'($urandom_range(0, 639)));
    send_gaps = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < MAP_DIM_DEF*MAP_DIM_DEF; i++) wall_cells[i] = 1'b0;
    cam_pos_x = '0;
    cam_pos_y = '0;
    cam_dir_x = 16384;
    cam_dir_y = 0;
    cam_plane_x = 0;
    cam_plane_y = 0;
    grid_cols = 64;
    grid_rows = 64;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_scenes();
    test_backpressure();
    wait_idle();
    $display("covered %0d casts (%0d wall hits, %0d left the grid) and %0d map writes",
             cast_count, hit_count, escaped_count, write_count);
    if (fail_count == 0) begin
      $display("grid_ray_caster_unit verification clean");
    end else begin
      $display("grid_ray_caster_unit verification failed");
    end
    $finish;
  end

endmodule

// File: grid_ray_caster_unit.f
src/gcr_pkg.sv
src/gcr_front.sv
src/gcr_div.sv
src/gcr_back.sv
src/grid_ray_caster_unit.sv
tb/sv/tb_grid_ray_caster_unit.sv
